// File: design/assert_macros.svh
// Assertion macros shared by the allocator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define QHA_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define QHA_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: design/qha_pkg.sv
// Types and constants for the query handle allocator.
`default_nettype none

package qha_pkg;

	localparam int ID_MAX_W  = 12;
	localparam int CNT_MAX_W = 13;
	localparam int CELL_LG   = 5;
	localparam int CELL_BITS = 32;

	localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

	localparam logic REQ_BEGIN = 1'b0;
	localparam logic REQ_GET   = 1'b1;

	localparam logic [1:0] OUTCOME_READY = 2'd0;

	localparam logic REG_ENABLED    = 1'b0;
	localparam logic REG_POOL_COUNT = 1'b1;

	typedef enum logic [2:0] {
		ST_OK,
		ST_DISABLED,
		ST_POOL_EMPTY,
		ST_INVALID,
		ST_NOT_BUSY
	} status_t;

	typedef struct packed {
		logic        req_type;
		logic [9:0]  slot_id;
		logic        slot_valid;
		logic [31:0] sample_count;
		logic [1:0]  device_outcome;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [9:0]  out_slot_id;
		logic        out_slot_valid;
		logic [9:0]  resource_order;
		logic [31:0] fragments;
		logic        culled;
	} rsp_t;

	typedef struct packed {
		logic                 reload;
		logic [CNT_MAX_W-1:0] lim;
		logic                 rel;
		logic [ID_MAX_W-1:0]  rel_ord;
		logic                 bset;
		logic                 bclr;
		logic [ID_MAX_W-1:0]  bid;
	} cell_cmd_t;

	typedef struct packed {
		logic                found;
		logic [ID_MAX_W-1:0] ord;
		logic                busy;
	} cell_rsp_t;

endpackage

`default_nettype wire

// File: design/qha_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module qha_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: design/qha_cell.sv
// One cell of the allocator chain: 32 free bits, 32 busy bits and a search token stage.
`default_nettype none

module qha_cell #(
	parameter int CELL_IDX  = 0,
	parameter int WW        = 10,
	parameter int RESET_LIM = 1024
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire qha_pkg::cell_cmd_t    cmd,
	input  wire logic                  tok_in,
	output logic                       tok_out,
	output qha_pkg::cell_rsp_t         rsp
);
	import qha_pkg::*;

	`include "assert_macros.svh"

	localparam logic [WW-1:0] IDX_W = WW'(CELL_IDX);

	logic [CELL_BITS-1:0] free_q;
	logic [CELL_BITS-1:0] busy_q;
	logic [CELL_BITS-1:0] low_bit;
	logic                 tok_q;
	logic                 found_q;
	logic [CELL_LG-1:0]   pick_q;
	logic [CELL_LG-1:0]   pick;
	logic [WW-1:0]        rel_w;
	logic [WW-1:0]        bid_w;
	logic                 rel_hit;
	logic                 bid_hit;
	logic                 any_free;

	// isolate the lowest free bit, then encode it
	always_comb begin
		low_bit = free_q & (~free_q + CELL_BITS'(1));
		pick    = '0;
		for (int j = 0; j < CELL_BITS; j++) begin
			if (low_bit[j]) begin
				pick = pick | CELL_LG'(j);
			end
		end
		any_free = free_q != '0;
		rel_w    = cmd.rel_ord[WW-1:0];
		bid_w    = cmd.bid[WW-1:0];
		rel_hit  = (rel_w >> CELL_LG) == IDX_W;
		bid_hit  = (bid_w >> CELL_LG) == IDX_W;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < CELL_BITS; j++) begin
				free_q[j] <= (CELL_IDX * CELL_BITS + j) < RESET_LIM;
			end
			busy_q  <= '0;
			tok_q   <= 1'b0;
			found_q <= 1'b0;
		end else begin
			// claim here, or pass the token on
			tok_q   <= tok_in && !any_free;
			found_q <= tok_in && any_free;
			if (tok_in && any_free) begin
				pick_q         <= pick;
				free_q[pick]   <= 1'b0;
			end
			if (cmd.rel && rel_hit) begin
				free_q[rel_w[CELL_LG-1:0]] <= 1'b1;
			end
			if (cmd.bset && bid_hit) begin
				busy_q[bid_w[CELL_LG-1:0]] <= 1'b1;
			end
			if (cmd.bclr && bid_hit) begin
				busy_q[bid_w[CELL_LG-1:0]] <= 1'b0;
			end
			if (cmd.reload) begin
				for (int j = 0; j < CELL_BITS; j++) begin
					free_q[j] <= (CELL_IDX * CELL_BITS + j) < int'(cmd.lim);
				end
				busy_q <= '0;
			end
		end
	end

	assign tok_out   = tok_q;
	assign rsp.found = found_q;
	assign rsp.ord   = ID_MAX_W'((IDX_W << CELL_LG) | WW'(pick_q));
	assign rsp.busy  = bid_hit && busy_q[bid_w[CELL_LG-1:0]];

	`QHA_ASSERT_ALWAYS(a_tok_or_found, !(tok_q && found_q), "cell both passed and claimed")
	`QHA_ASSERT_IMPLY(a_found_had_tok, found_q, $past(tok_in), "cell claimed without token")

endmodule

`default_nettype wire

// File: design/query_handle_allocator.sv
// Top level of the query handle allocator: control, registers, slot tables and cell chain.
//
//   port group   handshake             contents
//   req_*        req_valid/req_ready   begin or get request (qha_pkg::req_t)
//   rsp_*        rsp_valid/rsp_ready   one answer per request (qha_pkg::rsp_t)
//   apb          psel/penable/pwrite   enabled at 0x0, pool_count at 0x4
//
// A get passes check, release and answer on its way to the answer register.
// A begin passes check, search and answer; the search token walks one cell a cycle and is
// claimed at the first chain cell holding a free resource (32 resources per cell). If none
// is free, the token leaves the last cell; an error caught at the check goes to answer.
// Reset is asynchronous and needs no clearing pass; the free and busy bits sit in the cells.
// One request is worked on at a time; the next is accepted while an answer waits to be taken.
`default_nettype none

module query_handle_allocator #(
	parameter int QUERY_LIMIT = 1024
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire qha_pkg::req_t     req_data,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output qha_pkg::rsp_t          rsp_data,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [2:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready
);
	import qha_pkg::*;

	`include "assert_macros.svh"

	localparam int IW         = $clog2(QUERY_LIMIT);
	localparam int CW         = $clog2(QUERY_LIMIT + 1);
	localparam int NCELL      = (QUERY_LIMIT + CELL_BITS - 1) / CELL_BITS;
	localparam int CL         = $clog2(NCELL);
	localparam int WW         = CL + CELL_LG;
	localparam int POOL_RESET = 1024;
	localparam int RESET_LIM  = (POOL_RESET < QUERY_LIMIT) ? POOL_RESET : QUERY_LIMIT;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_RELEASE,
		S_RESP
	} state_t;

	state_t          state_q;
	req_t            req_q;
	rsp_t            res_q;
	rsp_t            rsp_q;
	logic            rsp_valid_q;
	logic            enabled_q;
	logic [10:0]     pool_count_q;
	logic [CW-1:0]   stack_cnt_q;
	logic [CW-1:0]   next_id_q;

	logic            cfg_wr;
	logic            id_avail;
	logic            sid_in_range;
	logic            start;
	logic            rsp_load;
	rsp_t            chk_res;
	logic [CW-1:0]   stack_top;
	logic [IW-1:0]   stack_rdata;
	logic [IW-1:0]   order_rdata;
	logic [IW-1:0]   new_id;
	logic [IW-1:0]   found_ord;
	logic            found_any;
	logic            busy_any;
	logic            stack_we;
	logic [31:0]     get_frag;
	logic [NCELL:0]  tok;
	logic [NCELL-1:0] found_vec;
	cell_cmd_t       cmd;
	cell_rsp_t       cell_rsp [NCELL];

	// APB: writes in the access phase, reads straight from the registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_POOL_COUNT) ? 32'(pool_count_q) : 32'(enabled_q);

	always_comb begin
		id_avail     = (stack_cnt_q != '0) || (next_id_q != CW'(QUERY_LIMIT));
		sid_in_range = int'(req_q.slot_id) < QUERY_LIMIT;
		stack_top    = stack_cnt_q - CW'(1);
		new_id       = (stack_cnt_q != '0) ? stack_rdata : next_id_q[IW-1:0];
		start        = (state_q == S_CHECK) && enabled_q &&
		               (req_q.req_type == REQ_BEGIN) && id_avail;
		stack_we     = (state_q == S_RELEASE) && (stack_cnt_q != CW'(QUERY_LIMIT));
		get_frag     = (req_q.device_outcome == OUTCOME_READY) ? req_q.sample_count : ALL_ONES;
		rsp_load     = (state_q == S_RESP) && (!rsp_valid_q || rsp_ready);

		// gather the chain: at most one cell reports a claim
		found_any = 1'b0;
		busy_any  = 1'b0;
		found_ord = '0;
		for (int i = 0; i < NCELL; i++) begin
			found_vec[i] = cell_rsp[i].found;
			found_any    = found_any | cell_rsp[i].found;
			busy_any     = busy_any | cell_rsp[i].busy;
			found_ord    = found_ord | (cell_rsp[i].found ? IW'(cell_rsp[i].ord) : '0);
		end

		// answer as decided at the check; ok means carry on to search or release
		chk_res = '{status: ST_OK, out_slot_id: '0, out_slot_valid: 1'b0,
		            resource_order: '0, fragments: ALL_ONES, culled: 1'b0};
		if (!enabled_q) begin
			chk_res.status = ST_DISABLED;
		end else if (req_q.req_type == REQ_BEGIN) begin
			chk_res.fragments = '0;
			if (!id_avail) begin
				chk_res.status = ST_POOL_EMPTY;
			end
		end else if (!req_q.slot_valid) begin
			chk_res.status = ST_INVALID;
		end else if (!sid_in_range || !busy_any) begin
			chk_res.status = ST_NOT_BUSY;
		end

		// broadcast to every cell
		cmd.reload  = cfg_wr && (paddr[2] == REG_POOL_COUNT);
		cmd.lim     = (CNT_MAX_W'(pwdata[10:0]) < CNT_MAX_W'(QUERY_LIMIT)) ?
		              CNT_MAX_W'(pwdata[10:0]) : CNT_MAX_W'(QUERY_LIMIT);
		cmd.rel     = state_q == S_RELEASE;
		cmd.rel_ord = ID_MAX_W'(order_rdata);
		cmd.bset    = (state_q == S_SCAN) && found_any;
		cmd.bclr    = state_q == S_RELEASE;
		cmd.bid     = (state_q == S_SCAN) ? ID_MAX_W'(new_id) : ID_MAX_W'(req_q.slot_id);
	end

	// slot id -> resource order
	qha_ram #(
		.WIDTH (IW),
		.DEPTH (QUERY_LIMIT)
	) u_order_ram (
		.clk   (clk),
		.we    (cmd.bset),
		.waddr (new_id),
		.wdata (found_ord),
		.raddr (IW'(req_q.slot_id)),
		.rdata (order_rdata)
	);

	// freed id stack, top at stack_cnt_q - 1
	qha_ram #(
		.WIDTH (IW),
		.DEPTH (QUERY_LIMIT)
	) u_stack_ram (
		.clk   (clk),
		.we    (stack_we),
		.waddr (stack_cnt_q[IW-1:0]),
		.wdata (IW'(req_q.slot_id)),
		.raddr (stack_top[IW-1:0]),
		.rdata (stack_rdata)
	);

	// token enters at cell 0; leaving the last cell means no free resource
	assign tok[0] = start;

	for (genvar g = 0; g < NCELL; g++) begin : g_cell
		qha_cell #(
			.CELL_IDX  (g),
			.WW        (WW),
			.RESET_LIM (RESET_LIM)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd),
			.tok_in  (tok[g]),
			.tok_out (tok[g+1]),
			.rsp     (cell_rsp[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			rsp_valid_q  <= 1'b0;
			enabled_q    <= 1'b1;
			pool_count_q <= 11'(POOL_RESET);
			stack_cnt_q  <= '0;
			next_id_q    <= '0;
		end else begin
			// raise the answer as it moves in, drop it once the transaction completes
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end

			if (cfg_wr) begin
				if (paddr[2] == REG_ENABLED) begin
					enabled_q <= pwdata[0];
				end else begin
					pool_count_q <= pwdata[10:0];
					stack_cnt_q  <= '0;
					next_id_q    <= '0;
				end
			end

			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						req_q   <= req_data;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					res_q <= chk_res;
					if (chk_res.status != ST_OK) begin
						state_q <= S_RESP;
					end else if (req_q.req_type == REQ_BEGIN) begin
						state_q <= S_SCAN;
					end else begin
						state_q <= S_RELEASE;
					end
				end
				S_SCAN: begin
					// wait for a claim or for the token to fall off the chain
					if (found_any) begin
						res_q.out_slot_id    <= 10'(new_id);
						res_q.out_slot_valid <= 1'b1;
						res_q.resource_order <= 10'(found_ord);
						if (stack_cnt_q != '0) begin
							stack_cnt_q <= stack_cnt_q - CW'(1);
						end else begin
							next_id_q <= next_id_q + CW'(1);
						end
						state_q <= S_RESP;
					end else if (tok[NCELL]) begin
						res_q.status <= ST_POOL_EMPTY;
						state_q      <= S_RESP;
					end
				end
				S_RELEASE: begin
					res_q.fragments <= get_frag;
					res_q.culled    <= get_frag == '0;
					if (stack_we) begin
						stack_cnt_q <= stack_cnt_q + CW'(1);
					end
					state_q <= S_RESP;
				end
				S_RESP: begin
					// hold until the answer register is free
					if (rsp_load) begin
						rsp_q   <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_ready = state_q == S_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	`QHA_ASSERT_ALWAYS(a_one_claim, $onehot0(found_vec), "more than one cell claimed")
	`QHA_ASSERT_IMPLY(a_scan_has_id, state_q == S_SCAN, id_avail, "search started with no id")
	`QHA_ASSERT_ALWAYS(a_next_id_bound, next_id_q <= CW'(QUERY_LIMIT), "next id beyond limit")
	`QHA_ASSERT_ALWAYS(a_stack_bound, stack_cnt_q <= CW'(QUERY_LIMIT), "stack overfilled")

endmodule

`default_nettype wire
